@@ rtl/sjt_pkg.sv @@
// Shared types, widths and constants of the screw joint transform core.
package sjt_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CORDIC_STEPS = 20;

   localparam int W_Q = 32;
   localparam int W_W = 16;
   localparam int W_DEG = 26;
   localparam int W_D = 24;
   localparam int W_CORD = 35;
   localparam int W_WW = 32;
   localparam int W_V = 35;
   localparam int W_TH = 22;
   localparam int W_THR = 30;

   localparam logic signed [27:0] DEG_TO_RAD_Q32 = 28'sd74961321;
   localparam logic signed [W_CORD-1:0] CORDIC_GAIN_Q30 = 35'sd652032874;
   localparam logic signed [26:0] TURN_Q16 = 27'sd23592960;
   localparam logic signed [26:0] HALF_TURN_Q16 = 27'sd11796480;
   localparam logic signed [26:0] QUARTER_TURN_Q16 = 27'sd5898240;
   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

   localparam logic signed [W_CORD-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
      35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
      35'sd67021687, 35'sd33543516, 35'sd16775851, 35'sd8388437,
      35'sd4194283, 35'sd2097149, 35'sd1048576, 35'sd524288, 35'sd262144,
      35'sd131072, 35'sd65536, 35'sd32768, 35'sd16384, 35'sd8192,
      35'sd4096, 35'sd2048
   };

   // matrix entry n = 3*row + col: w w product index, skew axis and skew sign
   localparam int WW_IDX [9] = '{0, 1, 2, 1, 3, 4, 2, 4, 5};
   localparam int SK_K [9] = '{0, 2, 1, 2, 0, 0, 1, 0, 0};
   localparam logic SK_NEG [9] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

   typedef struct packed {
      logic signed [W_Q-1:0] qx;
      logic signed [W_Q-1:0] qy;
      logic signed [W_Q-1:0] qz;
      logic signed [W_W-1:0] wx;
      logic signed [W_W-1:0] wy;
      logic signed [W_W-1:0] wz;
      logic signed [W_DEG-1:0] deg;
      logic signed [W_D-1:0] d;
      logic neg;
      logic ident;
   } item_type;

   typedef struct {
      logic signed [W_W-1:0] w [3];
      logic signed [W_WW-1:0] ww [6];
      logic signed [W_V-1:0] v [3];
      logic signed [W_TH-1:0] th;
      logic neg;
      logic ident;
   } side_type;

endpackage

@@ rtl/sjt_front.sv @@
// Front end: accepts words, folds the angle, classifies the axis, holds the threshold.
module sjt_front (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic signed [15:0] req_axis_z,
   input  logic signed [25:0] req_angle_deg,
   input  logic csr_valid,
   input  logic [sjt_pkg::W_THR-1:0] csr_data,
   input  logic [sjt_pkg::QCNT_W-1:0] queue_count,
   output logic push,
   output sjt_pkg::item_type push_item
);
   import sjt_pkg::*;

   logic [W_THR-1:0] thr_ff, thr_in;
   logic f1_vld_ff, f1_vld_in;
   item_type f1_item_ff, f1_item_in;
   logic [30:0] f1_sq_ff [3];
   logic [30:0] f1_sq_in [3];
   logic signed [31:0] sqx, sqy, sqz;
   logic signed [26:0] deg_x, r1;
   logic signed [26:0] dfold;
   logic nfold;
   logic [31:0] nsq;
   logic [QCNT_W:0] occupancy;
   logic accept;

   assign occupancy = {1'b0, queue_count} + (QCNT_W + 1)'(f1_vld_ff);
   assign busy = occupancy >= (QCNT_W + 1)'(QUEUE_DEPTH);
   assign accept = start & ~busy;

   assign sqx = req_axis_x * req_axis_x;
   assign sqy = req_axis_y * req_axis_y;
   assign sqz = req_axis_z * req_axis_z;

   always_comb begin
      deg_x = 27'(req_angle_deg);
      if (deg_x > HALF_TURN_Q16) begin
         r1 = deg_x - TURN_Q16;
      end else if (deg_x < -HALF_TURN_Q16) begin
         r1 = deg_x + TURN_Q16;
      end else begin
         r1 = deg_x;
      end
      if (r1 > QUARTER_TURN_Q16) begin
         dfold = r1 - HALF_TURN_Q16;
         nfold = 1'b1;
      end else if (r1 < -QUARTER_TURN_Q16) begin
         dfold = r1 + HALF_TURN_Q16;
         nfold = 1'b1;
      end else begin
         dfold = r1;
         nfold = 1'b0;
      end
   end

   always_comb begin
      thr_in = csr_valid ? csr_data : thr_ff;
      f1_vld_in = accept;
      f1_item_in.qx = req_point_x;
      f1_item_in.qy = req_point_y;
      f1_item_in.qz = req_point_z;
      f1_item_in.wx = req_axis_x;
      f1_item_in.wy = req_axis_y;
      f1_item_in.wz = req_axis_z;
      f1_item_in.deg = req_angle_deg;
      f1_item_in.d = dfold[W_D-1:0];
      f1_item_in.neg = nfold;
      f1_item_in.ident = 1'b0;
      f1_sq_in[0] = sqx[30:0];
      f1_sq_in[1] = sqy[30:0];
      f1_sq_in[2] = sqz[30:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
         f1_vld_ff <= 1'b0;
      end else begin
         thr_ff <= thr_in;
         f1_vld_ff <= f1_vld_in;
      end
      f1_item_ff <= f1_item_in;
      f1_sq_ff <= f1_sq_in;
   end

   assign nsq = {1'b0, f1_sq_ff[0]} + {1'b0, f1_sq_ff[1]} + {1'b0, f1_sq_ff[2]};

   always_comb begin
      push_item = f1_item_ff;
      push_item.ident = nsq <= {2'b00, thr_ff};
   end
   assign push = f1_vld_ff;

endmodule

@@ rtl/sjt_queue.sv @@
// Short queue between the front end and the back end.
module sjt_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  sjt_pkg::item_type push_item,
   input  logic pop,
   output sjt_pkg::item_type pop_item,
   output logic empty,
   output logic [sjt_pkg::QCNT_W-1:0] count
);
   import sjt_pkg::*;

   item_type mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = mem_ff[rd_ptr_ff];
   assign empty = cnt_ff == '0;
   assign count = cnt_ff;

endmodule

@@ rtl/sjt_cordic.sv @@
// Pipelined rotation-mode CORDIC, one step per stage, with side payload.
module sjt_cordic (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic signed [sjt_pkg::W_CORD-1:0] in_z,
   input  sjt_pkg::side_type in_side,
   output logic out_valid,
   output logic signed [sjt_pkg::W_CORD-1:0] out_x,
   output logic signed [sjt_pkg::W_CORD-1:0] out_y,
   output sjt_pkg::side_type out_side
);
   import sjt_pkg::*;

   logic vld_ff [CORDIC_STEPS];
   logic vld_in [CORDIC_STEPS];
   logic signed [W_CORD-1:0] x_ff [CORDIC_STEPS];
   logic signed [W_CORD-1:0] y_ff [CORDIC_STEPS];
   logic signed [W_CORD-1:0] z_ff [CORDIC_STEPS];
   logic signed [W_CORD-1:0] x_in [CORDIC_STEPS];
   logic signed [W_CORD-1:0] y_in [CORDIC_STEPS];
   logic signed [W_CORD-1:0] z_in [CORDIC_STEPS];
   side_type side_ff [CORDIC_STEPS];
   side_type side_in [CORDIC_STEPS];

   always_comb begin
      logic signed [W_CORD-1:0] xp, yp, zp, xs, ys;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (i == 0) begin
            xp = CORDIC_GAIN_Q30;
            yp = '0;
            zp = in_z;
            vld_in[i] = in_valid;
            side_in[i] = in_side;
         end else begin
            xp = x_ff[i-1];
            yp = y_ff[i-1];
            zp = z_ff[i-1];
            vld_in[i] = vld_ff[i-1];
            side_in[i] = side_ff[i-1];
         end
         xs = xp >>> i;
         ys = yp >>> i;
         if (!zp[W_CORD-1]) begin
            x_in[i] = xp - ys;
            y_in[i] = yp + xs;
            z_in[i] = zp - ATAN_Q30[i];
         end else begin
            x_in[i] = xp + ys;
            y_in[i] = yp - xs;
            z_in[i] = zp + ATAN_Q30[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_in[i];
         end
         x_ff[i] <= x_in[i];
         y_ff[i] <= y_in[i];
         z_ff[i] <= z_in[i];
         side_ff[i] <= side_in[i];
      end
   end

   assign out_valid = vld_ff[CORDIC_STEPS-1];
   assign out_x = x_ff[CORDIC_STEPS-1];
   assign out_y = y_ff[CORDIC_STEPS-1];
   assign out_side = side_ff[CORDIC_STEPS-1];

endmodule

@@ rtl/sjt_back.sv @@
// Back end: radians, v, CORDIC, Rodrigues matrix and translation pipeline.
module sjt_back (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  sjt_pkg::item_type in_item,
   output logic pop,
   output logic rsp_strobe,
   output logic signed [15:0] rsp_rot [9],
   output logic signed [31:0] rsp_trans [3]
);
   import sjt_pkg::*;

   // stage A
   logic a_vld_ff;
   item_type a_item_ff;
   // stage B
   logic b_vld_ff;
   logic signed [51:0] b_zp_ff, b_zp_in;
   logic signed [53:0] b_thp_ff, b_thp_in;
   logic signed [47:0] b_qw_ff [6];
   logic signed [47:0] b_qw_in [6];
   logic signed [W_WW-1:0] b_ww_ff [6];
   logic signed [W_WW-1:0] b_ww_in [6];
   logic signed [W_W-1:0] b_w_ff [3];
   logic signed [W_W-1:0] b_w_in [3];
   logic b_ident_ff, b_neg_ff;
   // stage C
   logic c_vld_ff;
   logic signed [W_CORD-1:0] c_z_ff, c_z_in;
   side_type c_side_ff, c_side_in;
   // CORDIC output
   logic k_vld;
   logic signed [W_CORD-1:0] k_x, k_y;
   side_type k_side;
   // stage D
   logic d_vld_ff;
   logic signed [W_CORD-1:0] d_c_ff, d_c_in, d_s_ff, d_s_in;
   logic signed [35:0] d_onemc_ff, d_onemc_in;
   logic signed [50:0] d_up_ff [6];
   logic signed [50:0] d_up_in [6];
   logic signed [50:0] d_dp_ff [3];
   logic signed [50:0] d_dp_in [3];
   side_type d_side_ff;
   // stage E
   logic e_vld_ff;
   logic signed [67:0] e_wwo_ff [6];
   logic signed [67:0] e_wwo_in [6];
   logic signed [50:0] e_sk_ff [3];
   logic signed [50:0] e_sk_in [3];
   logic signed [W_CORD-1:0] e_c_ff;
   logic signed [37:0] e_u_ff [3];
   logic signed [37:0] e_u_in [3];
   logic signed [38:0] e_dot_ff, e_dot_in;
   side_type e_side_ff;
   // stage F
   logic f_vld_ff;
   logic signed [15:0] f_r_ff [9];
   logic signed [15:0] f_r_in [9];
   logic signed [60:0] f_ep_ff, f_ep_in;
   logic signed [37:0] f_u_ff [3];
   logic signed [W_W-1:0] f_w_ff [3];
   // stage G
   logic g_vld_ff;
   logic signed [15:0] g_r_ff [9];
   logic signed [44:0] g_e_ff, g_e_in;
   logic signed [54:0] g_dr_ff [9];
   logic signed [54:0] g_dr_in [9];
   logic signed [W_W-1:0] g_w_ff [3];
   // stage H
   logic h_vld_ff;
   logic signed [15:0] h_r_ff [9];
   logic signed [60:0] h_we_ff [3];
   logic signed [60:0] h_we_in [3];
   logic signed [56:0] h_rs_ff [3];
   logic signed [56:0] h_rs_in [3];
   // stage I
   logic i_vld_ff;
   logic signed [15:0] i_r_ff [9];
   logic signed [31:0] i_t_ff [3];
   logic signed [31:0] i_t_in [3];

   assign pop = in_valid;

   // B: radians products, q x w and w w products
   always_comb begin
      b_zp_in = a_item_ff.d * DEG_TO_RAD_Q32;
      b_thp_in = a_item_ff.deg * DEG_TO_RAD_Q32;
      b_w_in[0] = a_item_ff.wx;
      b_w_in[1] = a_item_ff.wy;
      b_w_in[2] = a_item_ff.wz;
      b_qw_in[0] = a_item_ff.qy * a_item_ff.wz;
      b_qw_in[1] = a_item_ff.qz * a_item_ff.wy;
      b_qw_in[2] = a_item_ff.qz * a_item_ff.wx;
      b_qw_in[3] = a_item_ff.qx * a_item_ff.wz;
      b_qw_in[4] = a_item_ff.qx * a_item_ff.wy;
      b_qw_in[5] = a_item_ff.qy * a_item_ff.wx;
      b_ww_in[0] = a_item_ff.wx * a_item_ff.wx;
      b_ww_in[1] = a_item_ff.wx * a_item_ff.wy;
      b_ww_in[2] = a_item_ff.wx * a_item_ff.wz;
      b_ww_in[3] = a_item_ff.wy * a_item_ff.wy;
      b_ww_in[4] = a_item_ff.wy * a_item_ff.wz;
      b_ww_in[5] = a_item_ff.wz * a_item_ff.wz;
   end

   // C: rounding of z, theta and v
   always_comb begin
      logic signed [51:0] zr;
      logic signed [53:0] tr;
      logic signed [48:0] dv, vr;
      zr = (b_zp_ff + 52'sd131072) >>> 18;
      tr = (b_thp_ff + 54'sd2147483648) >>> 32;
      c_z_in = zr[W_CORD-1:0];
      c_side_in.th = tr[W_TH-1:0];
      for (int k = 0; k < 3; k++) begin
         dv = 49'(b_qw_ff[2*k]) - 49'(b_qw_ff[2*k+1]);
         vr = (dv + 49'sd8192) >>> 14;
         c_side_in.v[k] = vr[W_V-1:0];
         c_side_in.w[k] = b_w_ff[k];
      end
      c_side_in.ww = b_ww_ff;
      c_side_in.neg = b_neg_ff;
      c_side_in.ident = b_ident_ff;
   end

   sjt_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_vld_ff),
      .in_z      (c_z_ff),
      .in_side   (c_side_ff),
      .out_valid (k_vld),
      .out_x     (k_x),
      .out_y     (k_y),
      .out_side  (k_side)
   );

   // D: sign fix, 1 - c, w x v and w.v products
   always_comb begin
      d_c_in = k_side.neg ? -k_x : k_x;
      d_s_in = k_side.neg ? -k_y : k_y;
      d_onemc_in = (36'sd1 <<< 30) - 36'(d_c_in);
      d_up_in[0] = k_side.w[1] * k_side.v[2];
      d_up_in[1] = k_side.w[2] * k_side.v[1];
      d_up_in[2] = k_side.w[2] * k_side.v[0];
      d_up_in[3] = k_side.w[0] * k_side.v[2];
      d_up_in[4] = k_side.w[0] * k_side.v[1];
      d_up_in[5] = k_side.w[1] * k_side.v[0];
      for (int k = 0; k < 3; k++) begin
         d_dp_in[k] = k_side.w[k] * k_side.v[k];
      end
   end

   // E: matrix products, u and dot rounding
   always_comb begin
      logic signed [51:0] du, ur;
      logic signed [52:0] ds, dr;
      for (int k = 0; k < 6; k++) begin
         e_wwo_in[k] = d_side_ff.ww[k] * d_onemc_ff;
      end
      for (int k = 0; k < 3; k++) begin
         e_sk_in[k] = d_side_ff.w[k] * d_s_ff;
         du = 52'(d_up_ff[2*k]) - 52'(d_up_ff[2*k+1]);
         ur = (du + 52'sd8192) >>> 14;
         e_u_in[k] = ur[37:0];
      end
      ds = 53'(d_dp_ff[0]) + 53'(d_dp_ff[1]) + 53'(d_dp_ff[2]);
      dr = (ds + 53'sd8192) >>> 14;
      e_dot_in = dr[38:0];
   end

   // F: matrix entries, saturated, and the linear term product
   always_comb begin
      logic signed [69:0] term, acc, rr;
      for (int n = 0; n < 9; n++) begin
         if (n == 0 || n == 4 || n == 8) begin
            term = 70'(e_c_ff) <<< 28;
         end else if (SK_NEG[n]) begin
            term = -(70'(e_sk_ff[SK_K[n]]) <<< 14);
         end else begin
            term = 70'(e_sk_ff[SK_K[n]]) <<< 14;
         end
         acc = 70'(e_wwo_ff[WW_IDX[n]]) + term;
         rr = (acc + (70'sd1 <<< 43)) >>> 44;
         if (e_side_ff.ident) begin
            f_r_in[n] = (n == 0 || n == 4 || n == 8) ? ONE_Q14 : 16'sd0;
         end else if (rr > 70'sd32767) begin
            f_r_in[n] = 16'sd32767;
         end else if (rr < -70'sd32768) begin
            f_r_in[n] = -16'sd32768;
         end else begin
            f_r_in[n] = rr[15:0];
         end
      end
      f_ep_in = e_dot_ff * e_side_ff.th;
   end

   // G: linear term rounding, (I - R) u products
   always_comb begin
      logic signed [60:0] er;
      logic signed [16:0] im;
      er = (f_ep_ff + 61'sd32768) >>> 16;
      g_e_in = er[44:0];
      for (int n = 0; n < 9; n++) begin
         if (n == 0 || n == 4 || n == 8) begin
            im = 17'(ONE_Q14) - 17'(f_r_ff[n]);
         end else begin
            im = -17'(f_r_ff[n]);
         end
         g_dr_in[n] = im * f_u_ff[n % 3];
      end
   end

   // H: w e products and row sums
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         h_we_in[k] = g_w_ff[k] * g_e_ff;
         h_rs_in[k] = 57'(g_dr_ff[3*k]) + 57'(g_dr_ff[3*k+1]) + 57'(g_dr_ff[3*k+2]);
      end
   end

   // I: final rounding and saturation
   always_comb begin
      logic signed [61:0] tot, tr;
      for (int k = 0; k < 3; k++) begin
         tot = 62'(h_we_ff[k]) + 62'(h_rs_ff[k]);
         tr = (tot + 62'sd8192) >>> 14;
         if (tr > 62'sd2147483647) begin
            i_t_in[k] = 32'sh7fffffff;
         end else if (tr < -62'sd2147483648) begin
            i_t_in[k] = 32'sh80000000;
         end else begin
            i_t_in[k] = tr[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
         h_vld_ff <= 1'b0;
         i_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= k_vld;
         e_vld_ff <= d_vld_ff;
         f_vld_ff <= e_vld_ff;
         g_vld_ff <= f_vld_ff;
         h_vld_ff <= g_vld_ff;
         i_vld_ff <= h_vld_ff;
      end
      a_item_ff <= in_item;
      b_zp_ff <= b_zp_in;
      b_thp_ff <= b_thp_in;
      b_qw_ff <= b_qw_in;
      b_ww_ff <= b_ww_in;
      b_w_ff <= b_w_in;
      b_ident_ff <= a_item_ff.ident;
      b_neg_ff <= a_item_ff.neg;
      c_z_ff <= c_z_in;
      c_side_ff <= c_side_in;
      d_c_ff <= d_c_in;
      d_s_ff <= d_s_in;
      d_onemc_ff <= d_onemc_in;
      d_up_ff <= d_up_in;
      d_dp_ff <= d_dp_in;
      d_side_ff <= k_side;
      e_wwo_ff <= e_wwo_in;
      e_sk_ff <= e_sk_in;
      e_c_ff <= d_c_ff;
      e_u_ff <= e_u_in;
      e_dot_ff <= e_dot_in;
      e_side_ff <= d_side_ff;
      f_r_ff <= f_r_in;
      f_ep_ff <= f_ep_in;
      f_u_ff <= e_u_ff;
      f_w_ff <= e_side_ff.w;
      g_r_ff <= f_r_ff;
      g_e_ff <= g_e_in;
      g_dr_ff <= g_dr_in;
      g_w_ff <= f_w_ff;
      h_r_ff <= g_r_ff;
      h_we_ff <= h_we_in;
      h_rs_ff <= h_rs_in;
      i_r_ff <= h_r_ff;
      i_t_ff <= i_t_in;
   end

   assign rsp_strobe = i_vld_ff;
   assign rsp_rot = i_r_ff;
   assign rsp_trans = i_t_ff;

endmodule

@@ rtl/screw_joint_transform_core.sv @@
// A start word flows through the front register, queue, stages A-C, CORDIC, D-I.
// Throughput: one word per cycle; the back end runs a 20-stage CORDIC and a
// fixed multiplier pipeline that never stalls, so busy stays low in use.
// Reset (synchronous) empties the queue and pipeline and sets the threshold to 0.
// Result words last one cycle each; the receiver cannot hold them off.
module screw_joint_transform_core (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic signed [15:0] req_axis_z,
   input  logic signed [25:0] req_angle_deg,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [sjt_pkg::W_THR-1:0] csr_data,
   output logic rsp_strobe,
   output logic signed [15:0] rsp_rot_00,
   output logic signed [15:0] rsp_rot_01,
   output logic signed [15:0] rsp_rot_02,
   output logic signed [15:0] rsp_rot_10,
   output logic signed [15:0] rsp_rot_11,
   output logic signed [15:0] rsp_rot_12,
   output logic signed [15:0] rsp_rot_20,
   output logic signed [15:0] rsp_rot_21,
   output logic signed [15:0] rsp_rot_22,
   output logic signed [31:0] rsp_trans_x,
   output logic signed [31:0] rsp_trans_y,
   output logic signed [31:0] rsp_trans_z
);
   import sjt_pkg::*;

   logic push, pop, empty;
   item_type push_item, pop_item;
   logic [QCNT_W-1:0] queue_count;
   logic signed [15:0] rot [9];
   logic signed [31:0] trans [3];

   assign csr_ready = 1'b1;

   sjt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_point_z   (req_point_z),
      .req_axis_x    (req_axis_x),
      .req_axis_y    (req_axis_y),
      .req_axis_z    (req_axis_z),
      .req_angle_deg (req_angle_deg),
      .csr_valid     (csr_valid),
      .csr_data      (csr_data),
      .queue_count   (queue_count),
      .push          (push),
      .push_item     (push_item)
   );

   sjt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (empty),
      .count     (queue_count)
   );

   sjt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (~empty),
      .in_item    (pop_item),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_rot    (rot),
      .rsp_trans  (trans)
   );

   assign rsp_rot_00 = rot[0];
   assign rsp_rot_01 = rot[1];
   assign rsp_rot_02 = rot[2];
   assign rsp_rot_10 = rot[3];
   assign rsp_rot_11 = rot[4];
   assign rsp_rot_12 = rot[5];
   assign rsp_rot_20 = rot[6];
   assign rsp_rot_21 = rot[7];
   assign rsp_rot_22 = rot[8];
   assign rsp_trans_x = trans[0];
   assign rsp_trans_y = trans[1];
   assign rsp_trans_z = trans[2];

endmodule
